// ===== rtl/core/b64sd_pkg.sv =====
// ---------------------------------------------------------------------------
// b64sd_pkg: shared types and constants of the Base64 stream decoder
// Holds the character classification function and the job record that
// passes from the front part to the output part through the queue.
// ---------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_SLASH   = 8'd47;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

   localparam logic [7:0] LOWER_OFFSET = 8'd71;
   localparam logic [7:0] DIGIT_OFFSET = 8'd4;
   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;

   localparam logic [1:0] GROUP_FULL   = 2'd3;
   localparam logic [1:0] GROUP_PAIR   = 2'd2;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  count;
      logic        byte_valid;
      logic        stream_done;
   } job_type;

   function automatic sextet_type decode_char(input logic [7:0] c);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         s.value = 6'(c - LOWER_OFFSET);
      end else if (c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         s.value = 6'(c + DIGIT_OFFSET);
      end else if (c == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64sd_if.sv =====
// ---------------------------------------------------------------------------
// b64sd_if: stream channels of the Base64 stream decoder
// Character channel into the decoder and byte channel out of it.
// ---------------------------------------------------------------------------
`default_nettype none

interface b64sd_char_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64sd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       byte_valid;
   logic       run_last;
   logic       stream_done;

   modport source (output valid, output byte_value, output byte_valid,
                   output run_last, output stream_done, input ready);
   modport sink   (input valid, input byte_value, input byte_valid,
                   input run_last, input stream_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b64sd_front.sv =====
// ---------------------------------------------------------------------------
// b64sd_front: character classification and sextet collection
// Accepts one character per cycle while job_ready is high, packs sextets and issues byte jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [7:0]          char_code,
   input  wire logic                end_of_text,
   output logic                     job_valid,
   input  wire logic                job_ready,
   output b64sd_pkg::job_type       job
);

   logic [17:0] hold_ff, hold_in;
   logic [1:0]  count_ff, count_in;
   logic [17:0] shifted;
   logic [1:0]  count_inc;
   logic        accept;
   b64sd_pkg::sextet_type sx;

   assign in_ready = job_ready;
   assign accept   = in_valid && job_ready;

   always_comb begin
      sx        = b64sd_pkg::decode_char(char_code);
      shifted   = {hold_ff[11:0], sx.value};
      count_inc = 2'(count_ff + 2'd1);
      hold_in   = hold_ff;
      count_in  = count_ff;
      job_valid = 1'b0;
      job       = '0;
      if (sx.ok && count_ff == b64sd_pkg::GROUP_FULL) begin
         job_valid        = in_valid;
         job.bytes        = {hold_ff, sx.value};
         job.count        = b64sd_pkg::GROUP_FULL;
         job.byte_valid   = 1'b1;
         job.stream_done  = end_of_text;
         hold_in          = '0;
         count_in         = '0;
      end else begin
         if (sx.ok) begin
            hold_in  = shifted;
            count_in = count_inc;
         end
         if (end_of_text) begin
            job_valid       = in_valid;
            job.stream_done = 1'b1;
            job.byte_valid  = 1'b1;
            if (count_in == b64sd_pkg::GROUP_PAIR) begin
               job.bytes = {hold_in[11:4], 16'd0};
               job.count = 2'd1;
            end else if (count_in == b64sd_pkg::GROUP_FULL) begin
               job.bytes = {hold_in[17:2], 8'd0};
               job.count = 2'd2;
            end else begin
               job.count      = 2'd1;
               job.byte_valid = 1'b0;
            end
            hold_in  = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         hold_ff  <= hold_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64sd_queue.sv =====
// ---------------------------------------------------------------------------
// b64sd_queue: job queue between front and output parts
// Small first-in first-out buffer of byte jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire b64sd_pkg::job_type  in_job,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output b64sd_pkg::job_type       out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

   b64sd_pkg::job_type store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = fill_ff != FULL_COUNT;
   assign out_valid = fill_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         fill_in = CNT_W'(fill_ff + 1'b1);
      end else if (pop && !push) begin
         fill_in = CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64sd_back.sv =====
// ---------------------------------------------------------------------------
// b64sd_back: byte output sequencer
// Takes jobs from the queue and delivers their bytes one per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module b64sd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   output logic                     job_ready,
   input  wire b64sd_pkg::job_type  job,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               byte_value,
   output logic                     byte_valid,
   output logic                     run_last,
   output logic                     stream_done
);

   b64sd_pkg::job_type cur_ff;
   logic       busy_ff, busy_in;
   logic [1:0] index_ff, index_in;
   logic       fire, at_end;

   assign out_valid = busy_ff;
   assign fire      = busy_ff && out_ready;
   assign at_end    = index_ff == 2'(cur_ff.count - 2'd1);
   assign job_ready = !busy_ff || (fire && at_end);

   always_comb begin
      case (index_ff)
         2'd0:    byte_value = cur_ff.bytes[23:16];
         2'd1:    byte_value = cur_ff.bytes[15:8];
         default: byte_value = cur_ff.bytes[7:0];
      endcase
      byte_valid  = cur_ff.byte_valid;
      run_last    = at_end;
      stream_done = at_end && cur_ff.stream_done;
   end

   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      if (job_ready) begin
         busy_in  = job_valid;
         index_in = '0;
      end else if (fire) begin
         index_in = 2'(index_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready && job_valid) begin
         cur_ff <= job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 decoder
// Decodes a character stream into bytes, dropping non-alphabet characters.
// ---------------------------------------------------------------------------
// The decoder takes one character per cycle on req while its job queue has
// room. Each character that completes a group of four, and each character
// that marks the end of the text, places one job in a queue of QUEUE_DEPTH
// entries; the output sequencer then delivers that job's one to three bytes
// on rsp at one transaction per cycle while rsp is ready, with no gap
// between jobs. Every job is preceded by at least as many characters as it
// has bytes, so the output keeps up with a full-rate input, and the input
// stalls only when rsp is held off long enough to fill the queue. A job
// passes through the queue store and then the sequencer's job register
// before its first byte is offered on rsp. A result is registered and may
// wait on rsp while further characters are accepted.
`default_nettype none

module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   b64sd_char_if.sink   req,
   b64sd_byte_if.source rsp
);

   b64sd_pkg::job_type front_job, queue_job;
   logic front_valid, front_ready;
   logic queue_valid, queue_ready;

   b64sd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .char_code   (req.char_code),
      .end_of_text (req.end_of_text),
      .job_valid   (front_valid),
      .job_ready   (front_ready),
      .job         (front_job)
   );

   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_job   (queue_job)
   );

   b64sd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (queue_valid),
      .job_ready   (queue_ready),
      .job         (queue_job),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .byte_value  (rsp.byte_value),
      .byte_valid  (rsp.byte_valid),
      .run_last    (rsp.run_last),
      .stream_done (rsp.stream_done)
   );

endmodule

`default_nettype wire
